### rtl/tll_pkg.sv
package tll_pkg;

    localparam int MARGIN_DEFAULT   = 1024;
    localparam int POS_BITS_DEFAULT = 24;

    // tab cell is tab_cells (7 bits) times em_width (16 bits)
    localparam int CELL_W = 23;

    localparam logic [20:0] CODE_SPACE   = 21'h00020;
    localparam logic [20:0] CODE_TAB     = 21'h00009;
    localparam logic [20:0] CODE_NEWLINE = 21'h0000A;

    localparam logic [2:0] REG_AUTOWRAP       = 3'd0;
    localparam logic [2:0] REG_TAB_CELLS      = 3'd1;
    localparam logic [2:0] REG_EM_WIDTH       = 3'd2;
    localparam logic [2:0] REG_SPACE_WIDTH    = 3'd3;
    localparam logic [2:0] REG_LINE_PITCH     = 3'd4;
    localparam logic [2:0] REG_WRAP_WIDTH     = 3'd5;
    localparam logic [2:0] REG_FIRST_BASELINE = 3'd6;

    localparam logic [23:0] WRAP_WIDTH_RST     = 24'd163840;
    localparam logic [23:0] FIRST_BASELINE_RST = 24'd5120;

    typedef struct packed {
        logic [20:0]        glyph_code;
        logic [15:0]        font_advance;
        logic signed [15:0] kerning;
        logic               text_start;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] glyph_x;
        logic [23:0]        glyph_y;
        logic [23:0]        final_advance;
        logic [23:0]        content_width;
        logic [23:0]        content_height;
    } out_item_t;

    typedef struct packed {
        logic        autowrap_enable;
        logic [6:0]  tab_cells;
        logic [15:0] em_width;
        logic [15:0] space_width;
        logic [15:0] line_pitch;
        logic [23:0] wrap_width;
        logic [23:0] first_baseline;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        autowrap_enable: 1'b0,
        tab_cells:       7'd8,
        em_width:        16'd2048,
        space_width:     16'd1024,
        line_pitch:      16'd4096,
        wrap_width:      WRAP_WIDTH_RST,
        first_baseline:  FIRST_BASELINE_RST
    };

    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_SPACE,
        KIND_TAB,
        KIND_NEWLINE
    } kind_t;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_OTHER,
        CLS_SPACE,
        CLS_BREAK
    } cls_t;

    typedef struct packed {
        kind_t              kind;
        logic [15:0]        font_advance;
        logic signed [15:0] kerning;
        logic               text_start;
    } q_item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PREP,
        B_DIV,
        B_KERN,
        B_PLACE
    } bstate_t;

endpackage

### rtl/tll_front.sv
module tll_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tll_pkg::in_item_t  s_data,
    output logic               q_valid,
    output tll_pkg::q_item_t   q_item,
    input  logic               q_pop
);

    tll_pkg::q_item_t entry_reg [2];
    tll_pkg::q_item_t entry_in;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    always_comb begin
        case (s_data.glyph_code)
            tll_pkg::CODE_SPACE:   entry_in.kind = tll_pkg::KIND_SPACE;
            tll_pkg::CODE_TAB:     entry_in.kind = tll_pkg::KIND_TAB;
            tll_pkg::CODE_NEWLINE: entry_in.kind = tll_pkg::KIND_NEWLINE;
            default:               entry_in.kind = tll_pkg::KIND_OTHER;
        endcase
        entry_in.font_advance = s_data.font_advance;
        entry_in.kerning      = s_data.kerning;
        entry_in.text_start   = s_data.text_start;
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

### rtl/tll_rem.sv
module tll_rem #(
    parameter int DW = tll_pkg::POS_BITS_DEFAULT + 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [DW-1:0]              dividend,
    input  logic [tll_pkg::CELL_W-1:0] divisor,
    output logic                       done,
    output logic [tll_pkg::CELL_W-1:0] rem
);

    localparam int CW_CNT = (DW > 1) ? $clog2(DW) : 1;

    logic [DW-1:0]              shift_reg, shift_next;
    logic [tll_pkg::CELL_W-1:0] rem_reg, rem_next;
    logic [tll_pkg::CELL_W-1:0] div_reg, div_next;
    logic [CW_CNT-1:0]          cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [tll_pkg::CELL_W:0]   trial;

    // restoring step: one dividend bit per cycle, MSB first
    assign trial = {rem_reg, shift_reg[DW-1]};

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            shift_next = {shift_reg[DW-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = tll_pkg::CELL_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[tll_pkg::CELL_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW_CNT'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        cnt_reg   <= cnt_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### rtl/tll_back.sv
module tll_back #(
    parameter int MARGIN   = tll_pkg::MARGIN_DEFAULT,
    parameter int POS_BITS = tll_pkg::POS_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tll_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  tll_pkg::q_item_t    q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output tll_pkg::out_item_t  m_data
);

    localparam int P  = POS_BITS;
    localparam int CW = ((P > 24) ? P : 24) + 2;
    localparam int DW = P + 1;
    localparam int CL = tll_pkg::CELL_W;

    localparam logic signed [CW-1:0] XMAX  = {{(CW-P+1){1'b0}}, {(P-1){1'b1}}};
    localparam logic signed [CW-1:0] XMIN  = {{(CW-P+1){1'b1}}, {(P-1){1'b0}}};
    localparam logic signed [CW-1:0] UMAX  = {{(CW-P){1'b0}}, {P{1'b1}}};
    localparam logic signed [CW-1:0] S24MAX = {{(CW-23){1'b0}}, {23{1'b1}}};
    localparam logic signed [CW-1:0] S24MIN = {{(CW-23){1'b1}}, {23{1'b0}}};
    localparam logic signed [CW-1:0] U24MAX = {{(CW-24){1'b0}}, {24{1'b1}}};
    localparam logic signed [CW-1:0] MARGIN_C = CW'(MARGIN);
    localparam logic signed [P-1:0]  MARGIN_X =
        (MARGIN_C > XMAX) ? XMAX[P-1:0] : MARGIN_C[P-1:0];
    localparam logic signed [CW-1:0] WRAP_RST_C =
        {{(CW-24){1'b0}}, tll_pkg::WRAP_WIDTH_RST};
    localparam logic signed [CW-1:0] BASE_RST_C =
        {{(CW-24){1'b0}}, tll_pkg::FIRST_BASELINE_RST};
    localparam logic [P-1:0] WIDTH_RST =
        (WRAP_RST_C > UMAX) ? UMAX[P-1:0] : WRAP_RST_C[P-1:0];
    localparam logic [P-1:0] PEN_Y_RST =
        (BASE_RST_C > UMAX) ? UMAX[P-1:0] : BASE_RST_C[P-1:0];

    function automatic logic signed [CW-1:0] sx(input logic signed [P-1:0] v);
        return {{(CW-P){v[P-1]}}, v};
    endfunction

    function automatic logic signed [CW-1:0] ux(input logic [P-1:0] v);
        return {{(CW-P){1'b0}}, v};
    endfunction

    function automatic logic signed [P-1:0] sat_x(input logic signed [CW-1:0] v);
        if (v > XMAX) begin
            return XMAX[P-1:0];
        end else if (v < XMIN) begin
            return XMIN[P-1:0];
        end
        return v[P-1:0];
    endfunction

    function automatic logic [P-1:0] sat_u(input logic signed [CW-1:0] v);
        if (v[CW-1]) begin
            return '0;
        end else if (v > UMAX) begin
            return UMAX[P-1:0];
        end
        return v[P-1:0];
    endfunction

    function automatic logic signed [23:0] clamp_s24(input logic signed [CW-1:0] v);
        if (v > S24MAX) begin
            return S24MAX[23:0];
        end else if (v < S24MIN) begin
            return S24MIN[23:0];
        end
        return v[23:0];
    endfunction

    function automatic logic [23:0] clamp_u24(input logic signed [CW-1:0] v);
        if (v[CW-1]) begin
            return '0;
        end else if (v > U24MAX) begin
            return U24MAX[23:0];
        end
        return v[23:0];
    endfunction

    tll_pkg::bstate_t   state_reg, state_next;
    tll_pkg::q_item_t   item_reg, item_next;
    logic signed [P-1:0] pen_x_reg, pen_x_next;
    logic [P-1:0]       pen_y_reg, pen_y_next;
    tll_pkg::cls_t      prev_class_reg, prev_class_next;
    logic [P-1:0]       prev_adv_reg, prev_adv_next;
    logic [P-1:0]       width_reg, width_next;
    logic [P-1:0]       adv_reg, adv_next;
    logic               neg_reg, neg_next;
    logic [CL-1:0]      cell_reg, cell_next;
    logic               m_valid_reg, m_valid_next;
    tll_pkg::out_item_t m_data_reg, m_data_next;

    logic               out_free;
    logic [CL-1:0]      cell_c;
    logic signed [CW-1:0] dist_c, dist_abs;
    logic               tab_go;
    logic               div_done;
    logic [CL-1:0]      div_rem;

    assign out_free = !m_valid_reg || m_ready;
    assign cell_c   = CL'(cfg.tab_cells) * CL'(cfg.em_width);
    assign dist_c   = sx(pen_x_reg) - MARGIN_C;
    assign dist_abs = dist_c[CW-1] ? -dist_c : dist_c;
    assign tab_go   = (item_reg.kind == tll_pkg::KIND_TAB) && (cell_c != '0);

    tll_rem #(
        .DW(DW)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    ((state_reg == tll_pkg::B_PREP) && tab_go),
        .dividend (dist_abs[DW-1:0]),
        .divisor  (cell_c),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tll_pkg::B_IDLE: begin
                if (q_valid) begin
                    state_next = tll_pkg::B_PREP;
                end
            end
            tll_pkg::B_PREP: begin
                state_next = tab_go ? tll_pkg::B_DIV : tll_pkg::B_KERN;
            end
            tll_pkg::B_DIV: begin
                if (div_done) begin
                    state_next = tll_pkg::B_KERN;
                end
            end
            tll_pkg::B_KERN: begin
                state_next = tll_pkg::B_PLACE;
            end
            tll_pkg::B_PLACE: begin
                if (out_free) begin
                    state_next = tll_pkg::B_IDLE;
                end
            end
            default: state_next = tll_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        logic [23:0]          tab_adv;
        logic signed [CW-1:0] tab_ext;
        logic signed [CW-1:0] px, pitch;
        logic                 wrap_hit;
        logic signed [P-1:0]  px1;
        logic [P-1:0]         py1, py2;
        logic signed [P-1:0]  px2;
        logic [P-1:0]         wnext;

        item_next       = item_reg;
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        prev_class_next = prev_class_reg;
        prev_adv_next   = prev_adv_reg;
        width_next      = width_reg;
        adv_next        = adv_reg;
        neg_next        = neg_reg;
        cell_next       = cell_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        q_pop           = 1'b0;

        tab_adv  = '0;
        tab_ext  = '0;
        px       = sx(pen_x_reg);
        pitch    = {{(CW-16){1'b0}}, cfg.line_pitch};
        wrap_hit = 1'b0;
        px1      = pen_x_reg;
        py1      = pen_y_reg;
        py2      = pen_y_reg;
        px2      = pen_x_reg;
        wnext    = width_reg;

        case (state_reg)
            tll_pkg::B_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    if (q_item.text_start) begin
                        pen_x_next      = MARGIN_X;
                        pen_y_next      = sat_u({{(CW-24){1'b0}}, cfg.first_baseline});
                        prev_class_next = tll_pkg::CLS_NONE;
                        prev_adv_next   = '0;
                        width_next      = sat_u({{(CW-24){1'b0}}, cfg.wrap_width});
                    end
                end
            end
            tll_pkg::B_PREP: begin
                neg_next  = dist_c[CW-1];
                cell_next = cell_c;
                case (item_reg.kind)
                    tll_pkg::KIND_SPACE: begin
                        if (prev_class_reg == tll_pkg::CLS_NONE ||
                            prev_class_reg == tll_pkg::CLS_BREAK) begin
                            adv_next = P'(cfg.em_width);
                        end else if (prev_class_reg == tll_pkg::CLS_SPACE) begin
                            adv_next = prev_adv_reg;
                        end else begin
                            adv_next = P'(cfg.space_width);
                        end
                    end
                    tll_pkg::KIND_OTHER: adv_next = P'(item_reg.font_advance);
                    default:             adv_next = '0;
                endcase
            end
            tll_pkg::B_DIV: begin
                if (div_done) begin
                    // left of the margin the remainder is negative
                    if (neg_reg) begin
                        tab_adv = {1'b0, cell_reg} + {1'b0, div_rem};
                    end else begin
                        tab_adv = {1'b0, cell_reg} - {1'b0, div_rem};
                    end
                    if (tab_adv <= {9'd0, cfg.space_width[15:1]}) begin
                        tab_adv = tab_adv + {1'b0, cell_reg};
                    end
                    tab_ext  = {{(CW-24){1'b0}}, tab_adv};
                    adv_next = sat_u(tab_ext);
                end
            end
            tll_pkg::B_KERN: begin
                pen_x_next = sat_x(px + {{(CW-16){item_reg.kerning[15]}}, item_reg.kerning});
            end
            tll_pkg::B_PLACE: begin
                if (!cfg.autowrap_enable) begin
                    if (px + MARGIN_C > ux(width_reg)) begin
                        wnext = sat_u(px + MARGIN_C);
                    end
                end else begin
                    wrap_hit = (px + ux(adv_reg)) > (ux(width_reg) - MARGIN_C);
                end
                if (wrap_hit) begin
                    py1 = sat_u(ux(pen_y_reg) + pitch);
                    px1 = MARGIN_X;
                end
                px2 = sat_x(sx(px1) + ux(adv_reg));
                py2 = py1;
                if (item_reg.kind == tll_pkg::KIND_NEWLINE) begin
                    py2 = sat_u(ux(py1) + pitch);
                    px2 = MARGIN_X;
                end
                if (out_free) begin
                    pen_x_next    = px2;
                    pen_y_next    = py2;
                    width_next    = wnext;
                    prev_adv_next = adv_reg;
                    case (item_reg.kind)
                        tll_pkg::KIND_SPACE: prev_class_next = tll_pkg::CLS_SPACE;
                        tll_pkg::KIND_OTHER: prev_class_next = tll_pkg::CLS_OTHER;
                        default:             prev_class_next = tll_pkg::CLS_BREAK;
                    endcase
                    m_data_next.glyph_x        = clamp_s24(sx(px1));
                    m_data_next.glyph_y        = clamp_u24(ux(py1));
                    m_data_next.final_advance  = clamp_u24(ux(adv_reg));
                    m_data_next.content_width  = clamp_u24(ux(wnext));
                    m_data_next.content_height = clamp_u24(ux(py2));
                    m_valid_next               = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tll_pkg::B_IDLE;
            m_valid_reg    <= 1'b0;
            pen_x_reg      <= MARGIN_X;
            pen_y_reg      <= PEN_Y_RST;
            prev_class_reg <= tll_pkg::CLS_NONE;
            prev_adv_reg   <= '0;
            width_reg      <= WIDTH_RST;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            prev_class_reg <= prev_class_next;
            prev_adv_reg   <= prev_adv_next;
            width_reg      <= width_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        adv_reg    <= adv_next;
        neg_reg    <= neg_next;
        cell_reg   <= cell_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/text_line_layout.sv
// Each request passes the two-entry queue, then the placement engine states in order:
// idle (pop), prep, kern and place; a tab also waits in the div state for the
// remainder unit, which finds the tab cell offset one dividend bit per cycle.
// The engine works on one item at a time and holds in place until the output is free.
// A two-entry queue takes new requests while the placement engine works, until it is full.
// Reset (aresetn low, synchronous): registers to defaults, pen to margin, queue empty.
module text_line_layout #(
    parameter int MARGIN   = tll_pkg::MARGIN_DEFAULT,
    parameter int POS_BITS = tll_pkg::POS_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tll_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tll_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    tll_pkg::cfg_t    cfg_reg, cfg_next;
    logic             q_valid;
    logic             q_pop;
    tll_pkg::q_item_t q_item;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                tll_pkg::REG_AUTOWRAP:       cfg_next.autowrap_enable = cfg_data[0];
                tll_pkg::REG_TAB_CELLS:      cfg_next.tab_cells       = cfg_data[6:0];
                tll_pkg::REG_EM_WIDTH:       cfg_next.em_width        = cfg_data[15:0];
                tll_pkg::REG_SPACE_WIDTH:    cfg_next.space_width     = cfg_data[15:0];
                tll_pkg::REG_LINE_PITCH:     cfg_next.line_pitch      = cfg_data[15:0];
                tll_pkg::REG_WRAP_WIDTH:     cfg_next.wrap_width      = cfg_data;
                tll_pkg::REG_FIRST_BASELINE: cfg_next.first_baseline  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= tll_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tll_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    tll_back #(
        .MARGIN   (MARGIN),
        .POS_BITS (POS_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
